FILE: rtl/capability_handle_table_defines.svh
// Assertion macros for the capability handle table.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef CAPABILITY_HANDLE_TABLE_DEFINES_SVH
`define CAPABILITY_HANDLE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CHT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("capability handle table check failed");

// Next-cycle implication, disabled while reset is high.
`define CHT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("capability handle table check failed");

`endif

FILE: rtl/cht_pkg.sv
// Shared types, constants and helper functions for the capability handle table.
// No dependencies; cht_free_finder, cht_gen_unit and the top level import it.
package cht_pkg;

   localparam int SLOT_COUNT  = 64;
   localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int GROUP_COUNT = (SLOT_COUNT + 7) / 8;
   localparam int GROUP_W     = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int OUT_INDEX_W = 6;

   typedef enum logic [1:0] {
      OP_CREATE   = 2'd0,
      OP_RESTRICT = 2'd1,
      OP_REVOKE   = 2'd2,
      OP_VALIDATE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2,
      ST_RIGHTS  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_FIND,
      S_ALLOC
   } state_type;

   typedef struct packed {
      logic [31:0] generation;
      logic [31:0] rights;
      logic [31:0] rtype;
      logic [63:0] rid;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] index;
   } free_slot_type;

   typedef struct packed {
      logic        match;
      logic        subset;
      logic [31:0] next_gen;
   } gen_result_type;

   function automatic logic [2:0] lowest_of8(input logic [7:0] v);
      logic [2:0] r;
      r = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            r = 3'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [OUT_INDEX_W-1:0] out_index(input logic [SLOT_W-1:0] slot);
      logic [31:0] wide;
      wide = 32'(slot);
      return wide[OUT_INDEX_W-1:0];
   endfunction

endpackage

FILE: rtl/cht_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cht_free_finder.sv
// Registered lowest-free-slot finder over the slot used flags.
// Depends on cht_pkg for the slot count and the result struct.
module cht_free_finder (
   input  logic                            clock,
   input  logic [cht_pkg::SLOT_COUNT-1:0]  used,
   output cht_pkg::free_slot_type          free_slot
);
   import cht_pkg::*;

   logic [GROUP_COUNT*8-1:0] free_pad;
   logic [GROUP_COUNT-1:0]   grp_any;
   logic [2:0]               grp_low [GROUP_COUNT];
   logic [GROUP_W-1:0]       grp_sel;
   logic                     found;
   logic [GROUP_W+2:0]       full_index;
   free_slot_type            free_ff;
   free_slot_type            free_in;

   always_comb begin
      free_pad = '0;
      free_pad[SLOT_COUNT-1:0] = ~used;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         grp_any[g] = |free_pad[g*8 +: 8];
         grp_low[g] = lowest_of8(free_pad[g*8 +: 8]);
      end
   end

   always_comb begin
      found   = 1'b0;
      grp_sel = '0;
      for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            found   = 1'b1;
            grp_sel = GROUP_W'(g);
         end
      end
      full_index    = {grp_sel, grp_low[grp_sel]};
      free_in.found = found;
      free_in.index = SLOT_W'(full_index);
   end

   always_ff @(posedge clock) begin
      free_ff <= free_in;
   end

   assign free_slot = free_ff;

endmodule

FILE: rtl/cht_gen_unit.sv
// Shared generation and rights unit: compare, increment and subset check.
// Depends on cht_pkg for the result struct.
module cht_gen_unit (
   input  logic [31:0]             gen_a,
   input  logic [31:0]             gen_b,
   input  logic [31:0]             rights_have,
   input  logic [31:0]             rights_need,
   output cht_pkg::gen_result_type result
);
   import cht_pkg::*;

   always_comb begin
      result.match    = (gen_a == gen_b);
      result.next_gen = gen_a + 32'd1;
      result.subset   = ((rights_have & rights_need) == rights_need);
   end

endmodule

FILE: rtl/capability_handle_table.sv
// Top level of the capability handle table: sequencer, slot flags and response.
// Depends on cht_pkg, cht_ram, cht_free_finder, cht_gen_unit and the defines header.
//
// An item is accepted at a rising edge where start is high and busy is low.
// Every item gives exactly one result, shown for one cycle with rsp_valid high.
// The receiver cannot stall; results are never held back or dropped.
// The slot entries sit in one RAM with a registered read port, and the sequencer
// visits one state per table access.
// States visited after the accepting edge; the last one registers the result:
//   validate, revoke, or a handle that fails: S_LOOK
//   create: S_FIND, then S_ALLOC unless the table is full
//   restrict: S_LOOK, S_FIND, then S_ALLOC unless the table is full
// busy is high while the sequencer is in these states and drops in the cycle
// rsp_valid is shown, so the next item can be taken at the edge that ends it.
// Reset clears the used flags and the per-slot written flags at once; a slot
// never written reads as generation zero, so no clearing pass is needed and
// the block takes an item in the first cycle after reset.
`include "capability_handle_table_defines.svh"

module capability_handle_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_handle_index,
   input  logic [31:0] req_handle_generation,
   input  logic [31:0] req_resource_type,
   input  logic [63:0] req_resource_id,
   input  logic [31:0] req_rights_mask,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_new_index,
   output logic [31:0] rsp_new_generation
);
   import cht_pkg::*;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [31:0]            hidx_ff, hidx_in;
   logic [31:0]            hgen_ff, hgen_in;
   logic [31:0]            mask_ff, mask_in;
   logic [31:0]            ent_rights_ff, ent_rights_in;
   logic [31:0]            ent_type_ff, ent_type_in;
   logic [63:0]            ent_id_ff, ent_id_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SLOT_COUNT-1:0]  used_ff, used_in;
   logic [SLOT_COUNT-1:0]  written_ff, written_in;
   logic                   seen_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [OUT_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [31:0]            rsp_gen_ff, rsp_gen_in;

   logic [SLOT_W-1:0]      rd_addr;
   entry_type              rd_entry;
   logic [ENTRY_W-1:0]     rd_data;
   logic                   wr_en;
   entry_type              wr_entry;
   free_slot_type          free_slot;
   gen_result_type         gen_res;
   logic [31:0]            gen_a;
   logic                   in_range;
   logic                   resolved;

   cht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cht_free_finder u_free_finder (
      .clock     (clock),
      .used      (used_ff),
      .free_slot (free_slot)
   );

   cht_gen_unit u_gen_unit (
      .gen_a       (gen_a),
      .gen_b       (hgen_ff),
      .rights_have (rd_entry.rights),
      .rights_need (mask_ff),
      .result      (gen_res)
   );

   assign rd_entry = entry_type'(rd_data);
   assign in_range = (hidx_ff < 32'(SLOT_COUNT));
   assign resolved = in_range && used_ff[slot_ff] && gen_res.match;

   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = req_handle_index[SLOT_W-1:0];
         S_FIND:  rd_addr = free_slot.index;
         default: rd_addr = slot_ff;
      endcase
   end

   always_comb begin
      if (state_ff == S_ALLOC && !seen_ff) begin
         gen_a = 32'd0;
      end else begin
         gen_a = rd_entry.generation;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      hidx_ff       <= hidx_in;
      hgen_ff       <= hgen_in;
      mask_ff       <= mask_in;
      ent_rights_ff <= ent_rights_in;
      ent_type_ff   <= ent_type_in;
      ent_id_ff     <= ent_id_in;
      slot_ff       <= slot_in;
      seen_ff       <= written_ff[rd_addr];
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_gen_ff    <= rsp_gen_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      hidx_in       = hidx_ff;
      hgen_in       = hgen_ff;
      mask_in       = mask_ff;
      ent_rights_in = ent_rights_ff;
      ent_type_in   = ent_type_ff;
      ent_id_in     = ent_id_ff;
      slot_in       = slot_ff;
      used_in       = used_ff;
      written_in    = written_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_gen_in    = rsp_gen_ff;
      wr_en         = 1'b0;
      wr_entry      = rd_entry;
      wr_entry.generation = gen_res.next_gen;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in         = op_type'(req_op);
               hidx_in       = req_handle_index;
               hgen_in       = req_handle_generation;
               mask_in       = req_rights_mask;
               ent_rights_in = req_rights_mask;
               ent_type_in   = req_resource_type;
               ent_id_in     = req_resource_id;
               slot_in       = req_handle_index[SLOT_W-1:0];
               if (op_type'(req_op) == OP_CREATE) begin
                  state_in = S_FIND;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            rsp_index_in = '0;
            rsp_gen_in   = 32'd0;
            if (!resolved) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_INVALID;
               state_in      = S_IDLE;
            end else begin
               case (op_ff)
                  OP_REVOKE: begin
                     wr_en            = 1'b1;
                     used_in[slot_ff] = 1'b0;
                     rsp_valid_in     = 1'b1;
                     rsp_status_in    = ST_OK;
                     state_in         = S_IDLE;
                  end
                  OP_VALIDATE: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = gen_res.subset ? ST_OK : ST_RIGHTS;
                     state_in      = S_IDLE;
                  end
                  OP_RESTRICT: begin
                     ent_rights_in = rd_entry.rights & mask_ff;
                     ent_type_in   = rd_entry.rtype;
                     ent_id_in     = rd_entry.rid;
                     state_in      = S_FIND;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_FIND: begin
            if (!free_slot.found) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FULL;
               rsp_index_in  = '0;
               rsp_gen_in    = 32'd0;
               state_in      = S_IDLE;
            end else begin
               slot_in  = free_slot.index;
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            wr_en               = 1'b1;
            wr_entry.generation = gen_res.next_gen;
            wr_entry.rights     = ent_rights_ff;
            wr_entry.rtype      = ent_type_ff;
            wr_entry.rid        = ent_id_ff;
            used_in[slot_ff]    = 1'b1;
            written_in[slot_ff] = 1'b1;
            rsp_valid_in        = 1'b1;
            rsp_status_in       = ST_OK;
            rsp_index_in        = out_index(slot_ff);
            rsp_gen_in          = gen_res.next_gen;
            state_in            = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_new_index      = rsp_index_ff;
   assign rsp_new_generation = rsp_gen_ff;

   `CHT_ASSERT_NEXT(a_accept_sets_busy, clock, reset, start && !busy, busy)
   `CHT_ASSERT_NOW(a_result_after_work, clock, reset, rsp_valid, $past(busy) && !busy)
   `CHT_ASSERT_NOW(a_used_implies_written, clock, reset, 1'b1, (used_ff & ~written_ff) == '0)
   `CHT_ASSERT_NOW(a_alloc_target_free, clock, reset, state_ff == S_ALLOC, !used_ff[slot_ff])

endmodule
